// File: rtl/core/mprt_pkg.sv
// Shared types, constants and helpers for the map point rotate and tilt unit.
`timescale 1ns / 1ps
package mprt_pkg;

  localparam int MAX_POINTS_DEF   = 1024;
  localparam int CORDIC_STEPS_DEF = 16;

  // CORDIC vector width and angle accumulator width
  localparam int VW = 49;
  localparam int ZW = 34;

  // round(2^30 / K), K the CORDIC gain
  localparam logic signed [30:0]   INV_GAIN  = 31'sd652032874;
  localparam logic signed [VW-1:0] ROUND_Q15 = VW'(49'sd16384);
  localparam logic signed [ZW-1:0] ANG_PI    = 34'sd2147483648;
  localparam logic signed [15:0]   ANG_QTR   = 16'sd16384;

  // arctangent of 2^-i as 32-bit binary angles
  localparam logic [31:0] ATAN_TAB [0:23] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_TURN  = 2'd0;
  localparam logic [1:0] REG_TILT  = 2'd1;
  localparam logic [1:0] REG_COUNT = 2'd2;
  localparam logic [1:0] REG_TLEN  = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD0,
    ST_RDL,
    ST_RDI,
    ST_PNT,
    ST_MULX,
    ST_MULY,
    ST_TURN,
    ST_TURN_W,
    ST_TILT,
    ST_TILT_W,
    ST_MCOS,
    ST_MZS,
    ST_MZT,
    ST_OUT
  } mprt_state_t;

  typedef struct packed {
    logic               load;
    logic signed [15:0] angle;
  } cordic_ctl_t;

  function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
    logic signed [15:0] res;
    if (v > 48'sd32767) begin
      res = 16'h7FFF;
    end else if (v < -48'sd32768) begin
      res = 16'h8000;
    end else begin
      res = v[15:0];
    end
    return res;
  endfunction

endpackage

// File: rtl/core/mprt_cordic.sv
// Iterative CORDIC rotator, one micro-rotation per clock.
`timescale 1ns / 1ps
module mprt_cordic #(
  parameter int CORDIC_STEPS = mprt_pkg::CORDIC_STEPS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  mprt_pkg::cordic_ctl_t             ctl,
  input  logic signed [mprt_pkg::VW-1:0]    x_init,
  input  logic signed [mprt_pkg::VW-1:0]    y_init,
  output logic signed [mprt_pkg::VW-1:0]    x_out,
  output logic signed [mprt_pkg::VW-1:0]    y_out,
  output logic                              done
);
  import mprt_pkg::*;

  localparam int IW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam logic [IW-1:0] LAST = IW'(CORDIC_STEPS - 1);

  logic signed [VW-1:0] x_r, y_r, x_nxt, y_nxt, sx, sy;
  logic signed [ZW-1:0] z_r, z_nxt, z0, tab;
  logic [IW-1:0]        i_r;
  logic                 run_r;
  logic                 flip;

  always_comb begin
    // pre-rotate by pi when the angle lies beyond +/- pi/2
    z0   = ZW'(ctl.angle) <<< 16;
    flip = (ctl.angle > ANG_QTR) || (ctl.angle < -ANG_QTR);
    if (ctl.angle > ANG_QTR) begin
      z0 = z0 - ANG_PI;
    end else if (ctl.angle < -ANG_QTR) begin
      z0 = z0 + ANG_PI;
    end
    sx  = x_r >>> i_r;
    sy  = y_r >>> i_r;
    tab = ZW'($signed({1'b0, ATAN_TAB[5'(i_r)]}));
    x_nxt = x_r;
    y_nxt = y_r;
    z_nxt = z_r;
    if (ctl.load) begin
      x_nxt = flip ? -x_init : x_init;
      y_nxt = flip ? -y_init : y_init;
      z_nxt = z0;
    end else if (run_r) begin
      if (!z_r[ZW-1]) begin
        x_nxt = x_r - sy;
        y_nxt = y_r + sx;
        z_nxt = z_r - tab;
      end else begin
        x_nxt = x_r + sy;
        y_nxt = y_r - sx;
        z_nxt = z_r + tab;
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      i_r   <= '0;
    end else if (ctl.load) begin
      run_r <= 1'b1;
      i_r   <= '0;
    end else if (run_r) begin
      i_r <= i_r + IW'(1);
      if (i_r == LAST) begin
        run_r <= 1'b0;
      end
    end
  end

  assign x_out = x_r;
  assign y_out = y_r;
  assign done  = !run_r;

endmodule

// File: rtl/core/map_point_rotate_tilt_unit.sv
// Top level of the map point rotate and tilt unit: point store, sequencer, shared multiplier.
`timescale 1ns / 1ps
// Usage
//   Input stream (in_*): tuser = action (0 load, 1 read); tdata carries point_index and the
//   point (x, y, z). A load writes the point store in the transfer cycle and gives no result;
//   the unit is ready again in the next cycle. A read gives one result transfer on out_*.
//   Result stream (out_*): tdata = {out_y, out_x}, each 16-bit signed and saturated.
//   Config (APB): turn angle, tilt angle, point count, tile length at 0x0, 0x4, 0x8, 0xC.
//   Write config only while the unit is idle.
// Timing
//   A read runs three store reads, two multiplies, two CORDIC runs on one iterative rotator
//   (one step a clock), then three more multiplies on the single shared multiplier, and ends
//   with the result in the output register. in_tready is low for that time. Loads run at one
//   per cycle while the unit is idle.
// Reset / stall
//   rst_n (synchronous) clears the sequencer, the output valid and the config registers
//   (angles 0, point count 1, tile length 8). The point store is not cleared.
//   A stalled receiver holds the result in the output register; the next item is still taken,
//   and a following read waits in its last step until the output register frees.
module map_point_rotate_tilt_unit #(
  parameter int MAX_POINTS   = mprt_pkg::MAX_POINTS_DEF,
  parameter int CORDIC_STEPS = mprt_pkg::CORDIC_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [9:0] point_index, [25:10] in_x, [41:26] in_y,
                                  // [57:42] in_z, [63:58] zero
  input  logic        in_tuser,   // [0] action
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [15:0] out_x, [31:16] out_y
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mprt_pkg::*;

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = (AW + 1 > 11) ? AW + 1 : 11;

  // config registers
  logic signed [15:0] turn_r, tilt_r;
  logic [10:0]        pcount_r;
  logic [9:0]         tlen_r;

  // input fields
  logic               action;
  logic [9:0]         point_index;
  logic signed [15:0] in_x, in_y, in_z;

  mprt_state_t state_r, state_nxt;

  logic        in_acc, idx_ok, mem_we, out_load;
  logic [CW-1:0] cnt_c;
  logic [AW-1:0] last_addr, rd_addr, idx_r;
  logic          idx_ok_r;

  // point store: [15:0] x, [31:16] y, [47:32] z
  logic [47:0] mem [MAX_POINTS];
  logic [47:0] rdata_r;

  logic signed [15:0] p0x_r, p0y_r, cx_r, cy_r, pz_r;
  logic signed [16:0] dcx, dcy, hcx, hcy, dx_c, dy_c, dx_r, dy_r;
  logic signed [15:0] cx_c, cy_c, px_c, py_c;

  logic signed [VW-1:0] vx_r, vy_r;
  logic signed [33:0]   rx_r, ry_r;
  logic signed [50:0]   ycos_r;
  logic signed [32:0]   zs_r;
  logic signed [43:0]   zst_r;
  logic signed [21:0]   y1_r, y1_c;
  logic signed [15:0]   out_x_r, out_y_r;
  logic                 out_valid_r, out_valid_nxt;

  // shared multiplier
  logic signed [33:0] mul_a;
  logic signed [30:0] mul_b;
  logic signed [64:0] prod;

  // CORDIC
  cordic_ctl_t          cor_ctl;
  logic signed [VW-1:0] cor_x_init, cor_y_init, cor_x, cor_y;
  logic                 cor_done;
  logic signed [16:0]   cq_c, sq_c;

  // final arithmetic
  logic signed [34:0] s_ox, s_ox_adj;
  logic signed [51:0] t_y1, t_y1_adj;
  logic signed [45:0] u_oy, u_oy_adj;

  assign action      = in_tuser;
  assign point_index = in_tdata[9:0];
  assign in_x        = in_tdata[25:10];
  assign in_y        = in_tdata[41:26];
  assign in_z        = in_tdata[57:42];

  assign pready = 1'b1;

  // ---------------- configuration port ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      turn_r   <= '0;
      tilt_r   <= '0;
      pcount_r <= 11'd1;
      tlen_r   <= 10'd8;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_TURN:  turn_r   <= pwdata[15:0];
        REG_TILT:  tilt_r   <= pwdata[15:0];
        REG_COUNT: pcount_r <= pwdata[10:0];
        REG_TLEN:  tlen_r   <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_TURN:  prdata = {16'b0, turn_r};
      REG_TILT:  prdata = {16'b0, tilt_r};
      REG_COUNT: prdata = {21'b0, pcount_r};
      REG_TLEN:  prdata = {22'b0, tlen_r};
      default:   prdata = '0;
    endcase
  end

  // ---------------- point store ----------------
  assign in_acc = in_tvalid && in_tready;
  assign idx_ok = CW'(point_index) < CW'(MAX_POINTS);
  assign mem_we = in_acc && !action && idx_ok;

  // point count clamped to 1..MAX_POINTS; first and last entries set the centre
  always_comb begin
    if (pcount_r == 11'd0) begin
      cnt_c = CW'(1);
    end else if (CW'(pcount_r) > CW'(MAX_POINTS)) begin
      cnt_c = CW'(MAX_POINTS);
    end else begin
      cnt_c = CW'(pcount_r);
    end
    last_addr = AW'(cnt_c - CW'(1));
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[AW'(point_index)] <= {in_z, in_y, in_x};
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[rd_addr];
  end

  // ---------------- centre and offset ----------------
  always_comb begin
    // halving truncates toward zero
    dcx  = 17'($signed(rdata_r[15:0])) - 17'(p0x_r);
    dcy  = 17'($signed(rdata_r[31:16])) - 17'(p0y_r);
    hcx  = (dcx + (dcx[16] ? 17'sd1 : 17'sd0)) >>> 1;
    hcy  = (dcy + (dcy[16] ? 17'sd1 : 17'sd0)) >>> 1;
    cx_c = 16'(17'(p0x_r) + hcx);
    cy_c = 16'(17'(p0y_r) + hcy);
    // out-of-range read uses the origin
    px_c = idx_ok_r ? $signed(rdata_r[15:0])  : 16'sd0;
    py_c = idx_ok_r ? $signed(rdata_r[31:16]) : 16'sd0;
    dx_c = 17'(px_c) - 17'(cx_r);
    dy_c = 17'(cy_r) - 17'(py_c);   // y flipped
  end

  // ---------------- CORDIC ----------------
  mprt_cordic #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (cor_ctl),
    .x_init (cor_x_init),
    .y_init (cor_y_init),
    .x_out  (cor_x),
    .y_out  (cor_y),
    .done   (cor_done)
  );

  // cos / sin of tilt, rounded half up to Q1.15
  assign cq_c = 17'((cor_x + ROUND_Q15) >>> 15);
  assign sq_c = 17'((cor_y + ROUND_Q15) >>> 15);

  // ---------------- shared multiplier ----------------
  always_comb begin
    case (state_r)
      ST_MULX: begin
        mul_a = 34'(dx_r);
        mul_b = INV_GAIN;
      end
      ST_MULY: begin
        mul_a = 34'(dy_r);
        mul_b = INV_GAIN;
      end
      ST_MCOS: begin
        mul_a = ry_r;
        mul_b = 31'(cq_c);
      end
      ST_MZS: begin
        mul_a = 34'(pz_r);
        mul_b = 31'(sq_c);
      end
      ST_MZT: begin
        mul_a = 34'(zs_r);
        mul_b = 31'($signed({1'b0, tlen_r}));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = 65'(mul_a) * 65'(mul_b);

  // ---------------- result arithmetic ----------------
  always_comb begin
    // y1 = trunc((cy*2^30 - ry*cos) / 2^30), not saturated
    t_y1     = (52'(cy_r) <<< 30) - 52'(ycos_r);
    t_y1_adj = t_y1 + (t_y1[51] ? 52'sd1073741823 : 52'sd0);
    y1_c     = 22'(t_y1_adj >>> 30);
    // ox = trunc((rx + cx*2^15) / 2^15)
    s_ox     = 35'(rx_r) + (35'(cx_r) <<< 15);
    s_ox_adj = s_ox + (s_ox[34] ? 35'sd32767 : 35'sd0);
    // oy = trunc((y1*2^18 - z*sin*len) / 2^18)
    u_oy     = (46'(y1_r) <<< 18) - 46'(zst_r);
    u_oy_adj = u_oy + (u_oy[45] ? 46'sd262143 : 46'sd0);
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    in_tready  = 1'b0;
    rd_addr    = idx_r;
    cor_ctl    = '{load: 1'b0, angle: turn_r};
    cor_x_init = vx_r;
    cor_y_init = vy_r;
    out_load   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid && action) begin
          state_nxt = ST_RD0;
        end
      end
      ST_RD0: begin
        rd_addr   = '0;
        state_nxt = ST_RDL;
      end
      ST_RDL: begin
        rd_addr   = last_addr;
        state_nxt = ST_RDI;
      end
      ST_RDI:  state_nxt = ST_PNT;
      ST_PNT:  state_nxt = ST_MULX;
      ST_MULX: state_nxt = ST_MULY;
      ST_MULY: state_nxt = ST_TURN;
      ST_TURN: begin
        cor_ctl.load = 1'b1;
        state_nxt    = ST_TURN_W;
      end
      ST_TURN_W: begin
        if (cor_done) begin
          state_nxt = ST_TILT;
        end
      end
      ST_TILT: begin
        cor_ctl    = '{load: 1'b1, angle: tilt_r};
        cor_x_init = VW'(INV_GAIN);
        cor_y_init = '0;
        state_nxt  = ST_TILT_W;
      end
      ST_TILT_W: begin
        if (cor_done) begin
          state_nxt = ST_MCOS;
        end
      end
      ST_MCOS: state_nxt = ST_MZS;
      ST_MZS:  state_nxt = ST_MZT;
      ST_MZT:  state_nxt = ST_OUT;
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    out_valid_nxt = (out_valid_r && !out_tready) || out_load;
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          idx_r    <= AW'(point_index);
          idx_ok_r <= idx_ok;
        end
      end
      ST_RDL: begin
        p0x_r <= $signed(rdata_r[15:0]);
        p0y_r <= $signed(rdata_r[31:16]);
      end
      ST_RDI: begin
        cx_r <= cx_c;
        cy_r <= cy_c;
      end
      ST_PNT: begin
        dx_r <= dx_c;
        dy_r <= dy_c;
        pz_r <= idx_ok_r ? $signed(rdata_r[47:32]) : 16'sd0;
      end
      ST_MULX: vx_r <= $signed(prod[VW-1:0]);
      ST_MULY: vy_r <= $signed(prod[VW-1:0]);
      ST_TURN_W: begin
        if (cor_done) begin
          rx_r <= 34'(cor_x >>> 15);
          ry_r <= 34'(cor_y >>> 15);
        end
      end
      ST_MCOS: ycos_r <= $signed(prod[50:0]);
      ST_MZS:  zs_r   <= $signed(prod[32:0]);
      ST_MZT: begin
        zst_r <= $signed(prod[43:0]);
        y1_r  <= y1_c;
      end
      ST_OUT: begin
        if (out_load) begin
          out_x_r <= sat16(48'(s_ox_adj >>> 15));
          out_y_r <= sat16(48'(u_oy_adj >>> 18));
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_y_r, out_x_r};

endmodule

// File: verif/map_point_projection_checker.sv
// Channel monitor, point projection predictor and result comparison for the rotate and tilt unit.
`timescale 1ns / 1ps
package mprt_tb_pkg;

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_READ = 1'b1
  } point_action_t;

  // input tdata layout, lowest field last
  typedef struct packed {
    logic [5:0]         pad;
    logic signed [15:0] z;
    logic signed [15:0] y;
    logic signed [15:0] x;
    logic [9:0]         index;
  } point_word_t;

endpackage

module map_point_projection_checker #(
  parameter int MAX_POINTS   = 1024,
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending
);
  import mprt_tb_pkg::*;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
  } screen_pt_t;

  typedef struct {
    longint x;
    longint y;
  } vec_t;

  localparam longint INV_K        = 64'sd652032874;
  localparam longint QUARTER_TURN = 64'sd1073741824;
  localparam longint HALF_TURN    = 64'sd2147483648;
  localparam longint Q15_ONE      = 64'sd32768;
  localparam longint Q30_ONE      = 64'sd1073741824;
  localparam longint HEIGHT_ONE   = 64'sd262144;

  // atan(2^-i), 2^32 per full turn
  localparam logic [31:0] ARC_TAB [0:23] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  logic signed [15:0] store_x [MAX_POINTS];
  logic signed [15:0] store_y [MAX_POINTS];
  logic signed [15:0] store_z [MAX_POINTS];

  logic [15:0] turn_q;
  logic [15:0] tilt_q;
  logic [10:0] count_q;
  logic [9:0]  tile_q;

  screen_pt_t projected_q [$];
  int         errors = 0;

  function automatic vec_t rotate_vec(vec_t v, logic [15:0] ang);
    longint z;
    longint sx;
    longint sy;
    z = longint'($signed({ang, 16'h0000}));
    // fold into +-quarter turn
    if (z > QUARTER_TURN) begin
      v.x = -v.x;
      v.y = -v.y;
      z   = z - HALF_TURN;
    end else if (z < -QUARTER_TURN) begin
      v.x = -v.x;
      v.y = -v.y;
      z   = z + HALF_TURN;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      sx = v.x >>> i;
      sy = v.y >>> i;
      if (z >= 0) begin
        v.x = v.x - sy;
        v.y = v.y + sx;
        z   = z - longint'(ARC_TAB[i]);
      end else begin
        v.x = v.x + sy;
        v.y = v.y - sx;
        z   = z + longint'(ARC_TAB[i]);
      end
    end
    return v;
  endfunction

  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) begin
      return 16'sh7FFF;
    end
    if (v < -32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  function automatic screen_pt_t project_point(logic [9:0] idx);
    int unsigned used;
    longint      x0, y0, xl, yl, cx, cy, px, py, pz;
    longint      rx, ry, cq, sq, ox, y1, oy;
    vec_t        v;
    vec_t        t;
    screen_pt_t  r;
    used = count_q;
    if (used == 0) begin
      used = 1;
    end
    if (used > MAX_POINTS) begin
      used = MAX_POINTS;
    end
    x0 = store_x[0];
    y0 = store_y[0];
    xl = store_x[used - 1];
    yl = store_y[used - 1];
    cx = x0 + (xl - x0) / 2;
    cy = y0 + (yl - y0) / 2;
    px = 0;
    py = 0;
    pz = 0;
    if (idx < MAX_POINTS) begin
      px = store_x[idx];
      py = store_y[idx];
      pz = store_z[idx];
    end
    v.x = (px - cx) * INV_K;
    v.y = (cy - py) * INV_K;
    v   = rotate_vec(v, turn_q);
    rx  = v.x >>> 15;
    ry  = v.y >>> 15;
    t.x = INV_K;
    t.y = 0;
    t   = rotate_vec(t, tilt_q);
    cq  = (t.x + 16384) >>> 15;
    sq  = (t.y + 16384) >>> 15;
    ox  = (rx + cx * Q15_ONE) / Q15_ONE;
    y1  = (cy * Q30_ONE - ry * cq) / Q30_ONE;
    oy  = (y1 * HEIGHT_ONE - pz * sq * longint'(tile_q)) / HEIGHT_ONE;
    r.x = clamp16(ox);
    r.y = clamp16(oy);
    return r;
  endfunction

  task automatic report(string msg);
    errors++;
    if (errors <= 40) begin
      $display("%0t: %s", $realtime, msg);
    end
  endtask

  always @(posedge clk) begin
    point_word_t word;
    screen_pt_t  got;
    screen_pt_t  want;
    if (!rst_n) begin
      turn_q  <= 16'd0;
      tilt_q  <= 16'd0;
      count_q <= 11'd1;
      tile_q  <= 10'd8;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          mprt_pkg::REG_TURN:  turn_q  <= pwdata[15:0];
          mprt_pkg::REG_TILT:  tilt_q  <= pwdata[15:0];
          mprt_pkg::REG_COUNT: count_q <= pwdata[10:0];
          mprt_pkg::REG_TLEN:  tile_q  <= pwdata[9:0];
          default: ;
        endcase
      end
      // results first, so a read taken this edge cannot cover a stray result
      if (out_tvalid && out_tready) begin
        got.x = out_tdata[15:0];
        got.y = out_tdata[31:16];
        if (projected_q.size() == 0) begin
          report($sformatf("result (%0d, %0d) with nothing expected", got.x, got.y));
        end else begin
          want = projected_q.pop_front();
          if (got.x !== want.x) begin
            report($sformatf("out_x got %0d expected %0d", got.x, want.x));
          end
          if (got.y !== want.y) begin
            report($sformatf("out_y got %0d expected %0d", got.y, want.y));
          end
        end
      end
      if (in_tvalid && in_tready) begin
        word = in_tdata;
        if (in_tuser == ACT_LOAD) begin
          if (word.index < MAX_POINTS) begin
            store_x[word.index] = word.x;
            store_y[word.index] = word.y;
            store_z[word.index] = word.z;
          end
        end else begin
          projected_q.push_back(project_point(word.index));
        end
      end
    end
    pending    <= projected_q.size();
    fail_count <= errors;
  end

endmodule

// File: verif/map_point_rotate_tilt_unit_test.sv
// Stimulus, clock, reset and verdict for the map point rotate and tilt unit.
`timescale 1ns / 1ps
module map_point_rotate_tilt_unit_test;
  import mprt_tb_pkg::*;

  localparam int POINTS         = mprt_pkg::MAX_POINTS_DEF;
  localparam int STEPS          = mprt_pkg::CORDIC_STEPS_DEF;
  localparam int RESET_CYCLES   = 12;
  // read transfer to result register
  localparam int READ_LATENCY   = 2 * STEPS + 14;
  // longest quiet stretch of a good run is a long gap, one read and a long stall
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PHASES  = 10;
  localparam int PHASE_ITEMS    = 93;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata   = '0;
  logic        in_tuser   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        psel       = 1'b0;
  logic        penable    = 1'b0;
  logic        pwrite     = 1'b0;
  logic [3:0]  paddr      = '0;
  logic [31:0] pwdata     = '0;
  logic [31:0] prdata;
  logic        pready;

  int pending_results;
  int mismatch_total;

  // entries written so far; reads and the point count only ever touch these
  bit loaded [POINTS];
  int loaded_idx [$];

  bit gaps_on     = 1'b1;
  bit stalls_on   = 1'b1;
  int stall_left  = 0;
  int idle_cycles = 0;

  always #6 clk = ~clk;

  map_point_rotate_tilt_unit #(
    .MAX_POINTS  (POINTS),
    .CORDIC_STEPS(STEPS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  map_point_projection_checker #(
    .MAX_POINTS  (POINTS),
    .CORDIC_STEPS(STEPS)
  ) i_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .pready    (pready),
    .fail_count(mismatch_total),
    .pending   (pending_results)
  );

  // Result side back-pressure: mostly short stalls, the odd long one, none when calm.
  always @(posedge clk) begin
    int r;
    r = $urandom_range(0, 99);
    if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stalls_on && r < 25) begin
      out_tready <= 1'b0;
      stall_left <= (r < 22) ? $urandom_range(0, 3) : $urandom_range(10, 60);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Watchdog: ends the run after too long without any transfer or register access.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("map_point_rotate_tilt_unit verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Sender gap ahead of a transfer: mostly none or short, sometimes long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 60) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [15:0] pick_coord();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      return 16'($urandom);
    end
    if (r < 90) begin
      return 16'($urandom_range(0, 600) - 300);
    end
    case ($urandom_range(0, 3))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return 16'sh0000;
      default: return 16'shFFFF;
    endcase
  endfunction

  // Random, zero, half-turn ends and the quarter-turn fold boundary on both sides.
  function automatic logic [15:0] pick_angle();
    if ($urandom_range(0, 99) >= 30) begin
      return 16'($urandom);
    end
    case ($urandom_range(0, 6))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'h4000;
      4:       return 16'hC000;
      5:       return 16'h4001;
      default: return 16'hBFFF;
    endcase
  endfunction

  // Zero and oversize counts clamp; otherwise the last entry is one already loaded.
  function automatic logic [10:0] pick_count();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      return 11'd0;
    end
    if (r == 1) begin
      return 11'(1024 + $urandom_range(0, 1023));
    end
    return 11'(loaded_idx[$urandom_range(0, loaded_idx.size() - 1)] + 1);
  endfunction

  function automatic logic [9:0] pick_tile();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      return 10'd0;
    end
    if (r < 30) begin
      return 10'd1023;
    end
    return 10'($urandom_range(0, 1023));
  endfunction

  // One input transfer; returns at the edge where it was taken.
  task automatic send_word(point_action_t act, logic [9:0] idx,
                           logic signed [15:0] x, logic signed [15:0] y,
                           logic signed [15:0] z);
    point_word_t w;
    int          gap;
    w.pad   = '0;
    w.index = idx;
    w.x     = x;
    w.y     = y;
    w.z     = z;
    gap     = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= w;
    in_tuser  <= act;
    do @(posedge clk); while (!in_tready);
    if (act == ACT_LOAD && !loaded[idx]) begin
      loaded[idx] = 1'b1;
      loaded_idx.push_back(idx);
    end
  endtask

  // Hold off until every expected result is in, then let the sequencer settle.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
    repeat (READ_LATENCY) @(posedge clk);
  endtask

  // APB write: setup cycle, access cycle, then a spare cycle before the next.
  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(logic [15:0] turn, logic [15:0] tilt, logic [10:0] count,
                            logic [9:0] tile);
    wait_idle();
    write_reg(mprt_pkg::REG_TURN, {16'h0000, turn});
    write_reg(mprt_pkg::REG_TILT, {16'h0000, tilt});
    write_reg(mprt_pkg::REG_COUNT, {21'h0, count});
    write_reg(mprt_pkg::REG_TLEN, {22'h0, tile});
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset settings, single-point centre, zero tilt.
    send_word(ACT_LOAD, 10'd0, 16'sd100, -16'sd200, 16'sd50);
    send_word(ACT_READ, 10'd0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    // Coordinate extremes at entries 1023 and 1, plus all-zero and all-ones points.
    send_word(ACT_LOAD, 10'd1023, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
    send_word(ACT_LOAD, 10'd1, 16'sh8000, 16'sh7FFF, 16'sh8000);
    send_word(ACT_LOAD, 10'd2, 16'sh0000, 16'sh0000, 16'sh0000);
    send_word(ACT_LOAD, 10'd512, 16'shFFFF, 16'shFFFF, 16'shFFFF);
    send_word(ACT_READ, 10'd1023, 16'sh0000, 16'sh0000, 16'sh0000);
    send_word(ACT_READ, 10'd1, 16'shFFFF, 16'shFFFF, 16'shFFFF);

    // Near-half-turn rotation, minus half-turn tilt, oversize count, full tile length.
    set_config(16'h7FFF, 16'h8000, 11'd2047, 10'd1023);
    send_word(ACT_READ, 10'd0, 16'sd0, 16'sd0, 16'sd0);
    send_word(ACT_READ, 10'd1, 16'sd0, 16'sd0, 16'sd0);
    send_word(ACT_READ, 10'd1023, 16'sd0, 16'sd0, 16'sd0);
    send_word(ACT_READ, 10'd512, 16'sd0, 16'sd0, 16'sd0);
    send_word(ACT_READ, 10'd2, 16'sd0, 16'sd0, 16'sd0);

    // Exact quarter turn on both angles (no fold), zero count, zero tile length.
    set_config(16'h4000, 16'h4000, 11'd0, 10'd0);
    send_word(ACT_READ, 10'd1, 16'sd0, 16'sd0, 16'sd0);
    send_word(ACT_READ, 10'd1023, 16'sd0, 16'sd0, 16'sd0);

    // Most negative rotation, tilt just past a quarter turn, two-point centre.
    set_config(16'h8000, 16'h4001, 11'd2, 10'd512);
    send_word(ACT_READ, 10'd0, 16'sd0, 16'sd0, 16'sd0);
    send_word(ACT_READ, 10'd1, 16'sd0, 16'sd0, 16'sd0);
    send_word(ACT_READ, 10'd2, 16'sd0, 16'sd0, 16'sd0);
    send_word(ACT_READ, 10'd1023, 16'sd0, 16'sd0, 16'sd0);

    // Random phases; every fourth runs with no gaps or stalls at all.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      gaps_on   = (p % 4 != 3);
      stalls_on = gaps_on;
      set_config(pick_angle(), pick_angle(), pick_count(), pick_tile());
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // now and then drain everything mid-phase
        if ($urandom_range(0, 99) == 0) begin
          wait_idle();
        end
        if ($urandom_range(0, 99) < 45) begin
          send_word(ACT_LOAD,
                    ($urandom_range(0, 99) < 5) ? 10'd0 : 10'($urandom_range(0, 1023)),
                    pick_coord(), pick_coord(), pick_coord());
        end else begin
          send_word(ACT_READ, 10'(loaded_idx[$urandom_range(0, loaded_idx.size() - 1)]),
                    pick_coord(), pick_coord(), pick_coord());
        end
      end
    end

    wait_idle();
    if (mismatch_total == 0) begin
      $display("map_point_rotate_tilt_unit verification clean");
    end else begin
      $display("map_point_rotate_tilt_unit verification failed");
    end
    $finish;
  end

endmodule
